// ===== hw/rtl/heading_hold_drive_step_core_assert.svh =====
// Assertion macros shared by the heading hold drive step RTL.
`ifndef HEADING_HOLD_DRIVE_STEP_CORE_ASSERT_SVH
`define HEADING_HOLD_DRIVE_STEP_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define HHDS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("heading hold drive step assertion failed");
// Next-cycle implication, checked while out of reset.
`define HHDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heading hold drive step assertion failed");
`else
`define HHDS_ASSERT(lbl, clk, rstn, prop)
`define HHDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/hhds_pkg.sv =====
// Package of types and constants for the heading hold drive step core.
package hhds_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MOVE_KIND       = 3'd0;
    localparam logic [2:0] CFG_TARGET_DISTANCE = 3'd1;
    localparam logic [2:0] CFG_TARGET_HEADING  = 3'd2;
    localparam logic [2:0] CFG_BASE_SPEED      = 3'd3;
    localparam logic [2:0] CFG_GAIN            = 3'd4;

    // Move kinds
    localparam logic [1:0] KIND_ENC   = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_TURN  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam int         CFG_DATA_W    = 24;
    localparam int         NUM_STAGES    = 10;
    localparam logic [15:0] GAIN_RESET   = 16'd32768;
    localparam logic [14:0] ENC_SCALE_NUM = 15'd18846;
    // 9 * 32768 * 180, the fixed part of the turn command numerator
    localparam logic [25:0] TURN_BIAS    = 26'd53084160;
    localparam logic [8:0]  HALF_TURN    = 9'd180;
    localparam logic [8:0]  FULL_TURN    = 9'd360;

    // Load enables of the two register stages of a constant divider
    typedef struct packed {
        logic mul;
        logic fix;
    } t_hhds_div_en;

endpackage

// ===== hw/rtl/hhds_cdiv.sv =====
// Two-stage unsigned divide by a constant: reciprocal multiply, then one correction.
module hhds_cdiv import hhds_pkg::*; #(
    parameter int W  = 26,
    parameter int QW = 16,
    parameter int D  = 1000,
    parameter int S  = 32
) (
    input  logic          i_clk,
    input  t_hhds_div_en  i_en,
    input  logic [W-1:0]  i_x,
    output logic [QW-1:0] o_q
);

    localparam logic [S:0]   RECIP = (S+1)'((64'd1 << S) / D);
    localparam logic [W-1:0] DIV_W = W'(D);

    logic [W+S:0]    prod;
    logic [W-1:0]    r_x;
    logic [QW-1:0]   r_est;
    logic [W+QW-1:0] est_d;
    logic [W-1:0]    rem;
    logic            fix;
    logic [QW-1:0]   r_q;

    // estimate is the true quotient or one short
    assign prod  = {{(S+1){1'b0}}, i_x} * {{W{1'b0}}, RECIP};
    assign est_d = {{W{1'b0}}, r_est} * {{QW{1'b0}}, DIV_W};
    assign rem   = r_x - est_d[W-1:0];
    assign fix   = (rem >= DIV_W);

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_x   <= i_x;
            r_est <= prod[S +: QW];
        end
        if (i_en.fix) begin
            r_q <= r_est + {{(QW-1){1'b0}}, fix};
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/heading_hold_drive_step_core.sv =====
// Top level of the heading hold drive step core: config registers and a ten-stage pipeline.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per control
//   tick: gyro heading and position reading. Output channel (o_out_valid /
//   i_out_ready) returns one transaction per input: left drive, right drive and
//   the done flag.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, one
//   register per cycle, only while no transaction is in flight: a rule for the
//   user, which the block itself does not enforce.
//   Path: an accepted transaction passes ten register stages; the accepting edge
//   loads the first one and the last one is the output register.
//   Throughput: one transaction per cycle unless the receiver stalls; each stage holds
//   one item, and the widest step is a single reciprocal multiply of a constant divider.
//   Stall: each stage holds while the one after it is full and stalled, so a
//   stalled receiver fills the pipe and only then drops o_in_ready.
//   Reset: synchronous, active low; empties the pipe and returns the registers
//   to their reset values (gain 1.0, everything else zero).
`include "heading_hold_drive_step_core_assert.svh"
module heading_hold_drive_step_core import hhds_pkg::*; #(
    parameter int ENC_TOLERANCE      = 10,
    parameter int RANGE_TOLERANCE_MM = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [23:0]    i_gyro_angle,
    input  logic signed [23:0]    i_position_reading,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [15:0]    o_left_drive,
    output logic signed [15:0]    o_right_drive,
    output logic                  o_done_res
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         r_move_kind;
    logic signed [20:0] r_target_distance;
    logic signed [23:0] r_target_heading;
    logic [14:0]        r_base_speed;
    logic [15:0]        r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_kind       <= KIND_ENC;
            r_target_distance <= '0;
            r_target_heading  <= '0;
            r_base_speed      <= '0;
            r_gain            <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOVE_KIND:       r_move_kind       <= i_cfg_data[1:0];
                CFG_TARGET_DISTANCE: r_target_distance <= i_cfg_data[20:0];
                CFG_TARGET_HEADING:  r_target_heading  <= i_cfg_data[23:0];
                CFG_BASE_SPEED:      r_base_speed      <= i_cfg_data[14:0];
                CFG_GAIN:            r_gain            <= i_cfg_data[15:0];
                default: ;  // index beyond the register list: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads this cycle. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES:1]   vld_in;
    logic [NUM_STAGES+1:1] stg_rdy;

    always_comb begin
        stg_rdy[NUM_STAGES+1] = i_out_ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign vld_in = {r_vld[NUM_STAGES-1:1], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    assign o_in_ready  = stg_rdy[1];
    assign o_out_valid = r_vld[NUM_STAGES];

    // ------------------------------------------------------------------
    // Stage 1: heading error magnitude in whole degrees, position magnitude
    // ------------------------------------------------------------------
    logic signed [24:0] hdg_diff;
    logic [24:0]        hdg_abs;
    logic [23:0]        pos_abs;

    logic [15:0]        r1_aq;
    logic               r1_neg;
    logic [23:0]        r1_apos;
    logic               r1_pneg;
    logic signed [23:0] r1_pos;

    assign hdg_diff = {i_gyro_angle[23], i_gyro_angle}
                    - {r_target_heading[23], r_target_heading};
    // truncation toward zero: take the magnitude, drop the fraction bits
    assign hdg_abs  = hdg_diff[24] ? (25'd0 - hdg_diff) : hdg_diff;
    assign pos_abs  = i_position_reading[23] ? (24'd0 - i_position_reading)
                                             : i_position_reading;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r1_aq   <= hdg_abs[23:8];
            r1_neg  <= hdg_diff[24];
            r1_apos <= pos_abs;
            r1_pneg <= i_position_reading[23];
            r1_pos  <= i_position_reading;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: |error| / 360, and |pos| * 18846
    // ------------------------------------------------------------------
    logic [7:0]         q360;
    logic [38:0]        r2_penc;
    logic [15:0]        r2_aq;
    logic               r2_neg;
    logic               r2_pneg;
    logic signed [23:0] r2_pos;

    hhds_cdiv #(
        .W  (16),
        .QW (8),
        .D  (360),
        .S  (26)
    ) u_div360 (
        .i_clk (i_clk),
        .i_en  ('{mul: stg_rdy[2], fix: stg_rdy[3]}),
        .i_x   (r1_aq),
        .o_q   (q360)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r2_penc <= {15'd0, r1_apos} * {24'd0, ENC_SCALE_NUM};
            r2_aq   <= r1_aq;
            r2_neg  <= r1_neg;
            r2_pneg <= r1_pneg;
            r2_pos  <= r1_pos;
        end
    end

    // Stages 3-4: encoder distance = (|pos| * 18846 / 4096) / 1000
    logic [15:0]        q1000;
    logic [15:0]        r3_aq;
    logic               r3_neg;
    logic               r3_pneg;
    logic signed [23:0] r3_pos;

    hhds_cdiv #(
        .W  (26),
        .QW (16),
        .D  (1000),
        .S  (30)
    ) u_div1000 (
        .i_clk (i_clk),
        .i_en  ('{mul: stg_rdy[3], fix: stg_rdy[4]}),
        .i_x   (r2_penc[37:12]),
        .o_q   (q1000)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r3_aq   <= r2_aq;
            r3_neg  <= r2_neg;
            r3_pneg <= r2_pneg;
            r3_pos  <= r2_pos;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: remainder gives |d| in [0, 359]; sign of d is r4_neg
    // ------------------------------------------------------------------
    logic [16:0]        q360_x;
    logic [15:0]        ad_full;
    logic [8:0]         r4_ad;
    logic               r4_neg;
    logic               r4_pneg;
    logic signed [23:0] r4_pos;

    assign q360_x  = {9'd0, q360} * {8'd0, FULL_TURN};
    assign ad_full = r3_aq - q360_x[15:0];

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r4_ad   <= ad_full[8:0];
            r4_neg  <= r3_neg;
            r4_pneg <= r3_pneg;
            r4_pos  <= r3_pos;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: distance test, steering side, steering term, turn numerator
    // ------------------------------------------------------------------
    logic signed [24:0] cur_enc;
    logic signed [24:0] cur_pos;
    logic signed [24:0] dist_err;
    logic [24:0]        dist_abs;
    logic [24:0]        tol;
    logic               is_range;
    logic               in_tol;
    logic               back;
    logic               pside;
    logic [8:0]         dev;
    logic [8:0]         m_sel;
    logic [10:0]        m2;
    logic [10:0]        t_raw;
    logic [10:0]        t_abs;
    logic [7:0]         turn_e;
    logic [23:0]        turn_eg;

    logic               r5_within;
    logic               r5_back;
    logic               r5_dzero;
    logic               r5_pside;
    logic               r5_tneg;
    logic [9:0]         r5_mt;
    logic [25:0]        r5_tnum;

    assign is_range = (r_move_kind == KIND_RANGE);
    assign cur_enc  = r4_pneg ? (25'd0 - {9'd0, q1000}) : {9'd0, q1000};
    assign cur_pos  = is_range ? {r4_pos[23], r4_pos} : cur_enc;
    assign dist_err = cur_pos - {{4{r_target_distance[20]}}, r_target_distance};
    assign dist_abs = dist_err[24] ? (25'd0 - dist_err) : dist_err;
    assign tol      = is_range ? 25'(RANGE_TOLERANCE_MM) : 25'(ENC_TOLERANCE);
    assign in_tol   = (dist_abs < tol);
    // encoder: behind target when target > current; range: the reverse
    assign back     = is_range ? (!dist_err[24] && (dist_err != 25'sd0)) : dist_err[24];

    // positive side: d in (0, 180] or d below -180
    assign pside    = (!r4_neg && (r4_ad != 9'd0) && (r4_ad <= HALF_TURN))
                   || (r4_neg && (r4_ad > HALF_TURN));
    assign dev      = (r4_ad >= HALF_TURN) ? (r4_ad - HALF_TURN) : (HALF_TURN - r4_ad);
    assign m_sel    = back ? dev : r4_ad;
    assign m2       = {1'b0, m_sel, 1'b0};
    assign t_raw    = m2 - {2'd0, HALF_TURN};
    assign t_abs    = t_raw[10] ? ({2'd0, HALF_TURN} - m2) : t_raw;

    assign turn_e   = 8'(HALF_TURN - dev);
    assign turn_eg  = {16'd0, turn_e} * {8'd0, r_gain};

    always_ff @(posedge i_clk) begin
        if (stg_rdy[5]) begin
            r5_within <= in_tol;
            r5_back   <= back;
            r5_dzero  <= (r4_ad == 9'd0);
            r5_pside  <= pside;
            r5_tneg   <= t_raw[10];
            r5_mt     <= t_abs[9:0];
            r5_tnum   <= TURN_BIAS + {2'd0, turn_eg};
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: base * |2m - 180|; turn numerator / 1800 starts
    // ------------------------------------------------------------------
    logic [15:0] turn_v;
    logic [24:0] r6_p1;
    logic        r6_within;
    logic        r6_back;
    logic        r6_dzero;
    logic        r6_pside;
    logic        r6_tneg;

    hhds_cdiv #(
        .W  (26),
        .QW (16),
        .D  (1800),
        .S  (32)
    ) u_div1800 (
        .i_clk (i_clk),
        .i_en  ('{mul: stg_rdy[6], fix: stg_rdy[7]}),
        .i_x   (r5_tnum),
        .o_q   (turn_v)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[6]) begin
            r6_p1     <= {10'd0, r_base_speed} * {15'd0, r5_mt};
            r6_within <= r5_within;
            r6_back   <= r5_back;
            r6_dzero  <= r5_dzero;
            r6_pside  <= r5_pside;
            r6_tneg   <= r5_tneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: times gain
    // ------------------------------------------------------------------
    logic [40:0] r7_p;
    logic        r7_within;
    logic        r7_back;
    logic        r7_dzero;
    logic        r7_pside;
    logic        r7_tneg;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[7]) begin
            r7_p      <= {16'd0, r6_p1} * {25'd0, r_gain};
            r7_within <= r6_within;
            r7_back   <= r6_back;
            r7_dzero  <= r6_dzero;
            r7_pside  <= r6_pside;
            r7_tneg   <= r6_tneg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 8-9: (product / 32768) / 180 gives the steering magnitude
    // ------------------------------------------------------------------
    logic [17:0] steer_mag;
    logic [15:0] r8_v;
    logic        r8_within;
    logic        r8_back;
    logic        r8_dzero;
    logic        r8_pside;
    logic        r8_tneg;

    hhds_cdiv #(
        .W  (26),
        .QW (18),
        .D  (180),
        .S  (32)
    ) u_div180 (
        .i_clk (i_clk),
        .i_en  ('{mul: stg_rdy[8], fix: stg_rdy[9]}),
        .i_x   (r7_p[40:15]),
        .o_q   (steer_mag)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[8]) begin
            r8_v      <= turn_v;
            r8_within <= r7_within;
            r8_back   <= r7_back;
            r8_dzero  <= r7_dzero;
            r8_pside  <= r7_pside;
            r8_tneg   <= r7_tneg;
        end
    end

    logic [15:0] r9_v;
    logic        r9_within;
    logic        r9_back;
    logic        r9_dzero;
    logic        r9_pside;
    logic        r9_tneg;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[9]) begin
            r9_v      <= r8_v;
            r9_within <= r8_within;
            r9_back   <= r8_back;
            r9_dzero  <= r8_dzero;
            r9_pside  <= r8_pside;
            r9_tneg   <= r8_tneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: saturation and side selection into the output register
    // ------------------------------------------------------------------
    logic [17:0] steer_neg;
    logic [15:0] steer_sat;
    logic [15:0] dir_val;
    logic [15:0] turn_pos;
    logic [15:0] turn_neg;
    logic [15:0] n_left;
    logic [15:0] n_right;
    logic        n_done;

    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic               r_done;

    assign steer_neg = 18'd0 - steer_mag;

    always_comb begin
        // sign of the steering command: direction sign times term sign
        if (r9_back ^ r9_tneg) begin
            steer_sat = (steer_mag > 18'd32768) ? 16'h8000 : steer_neg[15:0];
        end else begin
            steer_sat = (steer_mag > 18'd32767) ? 16'h7FFF : steer_mag[15:0];
        end
        dir_val  = r9_back ? (16'd0 - {1'b0, r_base_speed}) : {1'b0, r_base_speed};
        turn_pos = (r9_v > 16'd32767) ? 16'h7FFF : r9_v;
        turn_neg = (r9_v > 16'd32768) ? 16'h8000 : (16'd0 - r9_v);

        n_left  = '0;
        n_right = '0;
        n_done  = 1'b0;
        case (r_move_kind) inside
            KIND_ENC, KIND_RANGE: begin
                if (r9_within) begin
                    n_done = 1'b1;
                end else if (r9_dzero) begin
                    n_left  = dir_val;
                    n_right = dir_val;
                end else if (r9_pside) begin
                    n_left  = steer_sat;
                    n_right = dir_val;
                end else begin
                    n_left  = dir_val;
                    n_right = steer_sat;
                end
            end
            KIND_TURN: begin
                if (r9_dzero) begin
                    n_done = 1'b1;
                end else if (r9_pside) begin
                    n_left  = turn_pos;
                    n_right = turn_neg;
                end else begin
                    n_left  = turn_neg;
                    n_right = turn_pos;
                end
            end
            default: ;  // unused kind: drives zero, not done
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[10]) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_done  <= n_done;
        end
    end

    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_done_res    = r_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HHDS_ASSERT(a_done_drives_zero, i_clk, i_rst_n,
        o_out_valid && o_done_res |-> o_left_drive == 16'sd0 && o_right_drive == 16'sd0)
    `HHDS_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready |-> &r_vld)
    `HHDS_ASSERT(a_heading_rem_range, i_clk, i_rst_n, r_vld[4] |-> r4_ad < FULL_TURN)
    `HHDS_ASSERT(a_unused_kind_idle, i_clk, i_rst_n,
        o_out_valid && r_move_kind == KIND_NONE
        |-> !o_done_res && o_left_drive == 16'sd0 && o_right_drive == 16'sd0)
    `HHDS_ASSERT_NEXT(a_item_reaches_output, i_clk, i_rst_n,
        r_vld[NUM_STAGES-1] && stg_rdy[NUM_STAGES], r_vld[NUM_STAGES])

endmodule
